@@ design/mvp_pkg.sv @@
// Shared constants and types of the matrix-vector product unit.
`timescale 1ns / 1ps

package mvp_pkg;

  localparam int unsigned COLS_MAX   = 256;
  localparam int unsigned ROWS_MAX   = 4096;
  localparam int unsigned VEC_AW     = $clog2(COLS_MAX);
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned ROWS_CFG_W = 13;
  localparam int unsigned COLS_CFG_W = 9;
  localparam int unsigned CFG_DW     = 13;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_NEG_MAX = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    KIND_VECTOR = 1'b0,
    KIND_MATRIX = 1'b1
  } item_kind_e;

  // control that travels with a matrix element through the MAC stages
  typedef struct packed {
    logic             valid;
    logic             col0;
    logic             lastcol;
    logic             lastrow;
    logic [ROW_W-1:0] row;
  } mac_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             lastcol;
    logic             lastrow;
    logic [ROW_W-1:0] row;
    logic [ACC_W-1:0] acc;
  } mac_res_t;

endpackage

@@ design/mvp_vec_store.sv @@
// Vector store: 256 x 32 synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module mvp_vec_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [mvp_pkg::VEC_AW-1:0] waddr_i,
  input  logic [mvp_pkg::VAL_W-1:0]  wdata_i,
  input  logic                      re_i,
  input  logic [mvp_pkg::VEC_AW-1:0] raddr_i,
  output logic [mvp_pkg::VAL_W-1:0]  rdata_o
);
  import mvp_pkg::*;

  logic [VAL_W-1:0] mem_q [COLS_MAX];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mvp_mac.sv @@
// Multiply stage and saturating 64-bit accumulator.
`timescale 1ns / 1ps

module mvp_mac (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  mvp_pkg::mac_ctl_t        ctl_i,
  input  logic [mvp_pkg::VAL_W-1:0] a_i,
  input  logic [mvp_pkg::VAL_W-1:0] x_i,
  output mvp_pkg::mac_res_t        res_o,
  output mvp_pkg::mac_res_t        res_d_o
);
  import mvp_pkg::*;

  mac_ctl_t         s2_ctl_q;
  logic [ACC_W-1:0] prod_q;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] acc_base, sum;
  logic             ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (en_i) begin
      s2_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ACC_W'($signed(a_i) * $signed(x_i));
    end
  end

  // accumulator restarts at column zero
  assign acc_base = s2_ctl_q.col0 ? '0 : acc_q;
  assign sum      = acc_base + prod_q;
  assign ovf      = (acc_base[ACC_W-1] == prod_q[ACC_W-1]) &&
                    (sum[ACC_W-1] != acc_base[ACC_W-1]);

  always_comb begin
    acc_d = sum;
    if (ovf) begin
      acc_d = acc_base[ACC_W-1] ? ACC_NEG_MAX : ACC_POS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i && s2_ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign res_o = '{valid:   s2_ctl_q.valid,
                   lastcol: s2_ctl_q.lastcol,
                   lastrow: s2_ctl_q.lastrow,
                   row:     s2_ctl_q.row,
                   acc:     acc_q};

  assign res_d_o = '{valid:   s2_ctl_q.valid,
                     lastcol: s2_ctl_q.lastcol,
                     lastrow: s2_ctl_q.lastrow,
                     row:     s2_ctl_q.row,
                     acc:     acc_d};

endmodule

@@ design/matrix_vector_product_unit.sv @@
// Top level of the matrix-vector product unit: decode, RAM read stage, MAC, output register.
//
//  channel   | dir | handshake                    | contents
//  s_axis    | in  | tvalid/tready                | tuser: kind; tdata: row, col, value
//  m_axis    | out | tvalid/tready                | tlast: last; tdata: out_row, out_value
//  cfg       | in  | cfg_we_i                     | cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while the output is not stalled; a result is presented once its last
// column is accepted and has passed RAM read, multiply, then accumulate into the output register.
// The accumulator register loop is one 64-bit add with saturation per cycle.
// Reset clears control and the accumulator; the vector RAM is not cleared.
// A stalled output freezes the whole pipeline and drops s_axis_tready.
`timescale 1ns / 1ps

module matrix_vector_product_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [mvp_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] row, [19:12] col, [51:20] value, [55:52] zero
  input  logic [mvp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [11:0] out_row, [75:12] out_value, [79:76] zero
  output logic [mvp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import mvp_pkg::*;

  logic [ROWS_CFG_W-1:0] rows_q;
  logic [COLS_CFG_W-1:0] cols_q;
  logic [ROWS_CFG_W-1:0] nrows;
  logic [COLS_CFG_W-1:0] ncols;

  logic             en;
  logic             acc_in;
  item_kind_e       kind;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [VAL_W-1:0] in_val;
  logic             mat_ok;
  mac_ctl_t         s1_ctl_d, s1_ctl_q;
  logic [VAL_W-1:0] s1_val_q;
  logic [VAL_W-1:0] x_rd;
  mac_res_t         res, res_d;

  logic             out_valid_q;
  logic [ROW_W-1:0] out_row_q;
  logic [ACC_W-1:0] out_val_q;
  logic             out_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_CFG_W'(1);
      cols_q <= COLS_CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROWS: rows_q <= cfg_wdata_i[ROWS_CFG_W-1:0];
        REG_COLS: cols_q <= cfg_wdata_i[COLS_CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    nrows = rows_q;
    if (rows_q == '0) begin
      nrows = ROWS_CFG_W'(1);
    end else if (rows_q > ROWS_CFG_W'(ROWS_MAX)) begin
      nrows = ROWS_CFG_W'(ROWS_MAX);
    end
    ncols = cols_q;
    if (cols_q == '0) begin
      ncols = COLS_CFG_W'(1);
    end else if (cols_q > COLS_CFG_W'(COLS_MAX)) begin
      ncols = COLS_CFG_W'(COLS_MAX);
    end
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc_in        = s_axis_tvalid && en;

  assign kind   = item_kind_e'(s_axis_tuser);
  assign in_row = s_axis_tdata[11:0];
  assign in_col = s_axis_tdata[19:12];
  assign in_val = s_axis_tdata[51:20];
  assign mat_ok = acc_in && (kind == KIND_MATRIX) && ({1'b0, in_col} < ncols);

  always_comb begin
    s1_ctl_d.valid   = mat_ok;
    s1_ctl_d.col0    = (in_col == '0);
    s1_ctl_d.lastcol = ({1'b0, in_col} == ncols - COLS_CFG_W'(1));
    s1_ctl_d.lastrow = ({1'b0, in_row} == nrows - ROWS_CFG_W'(1));
    s1_ctl_d.row     = in_row;
  end

  // a vector load and a matrix read never share a cycle, so no bypass is needed
  mvp_vec_store u_store (
    .clk_i   (clk_i),
    .we_i    (acc_in && (kind == KIND_VECTOR)),
    .waddr_i (in_col),
    .wdata_i (in_val),
    .re_i    (mat_ok),
    .raddr_i (in_col),
    .rdata_o (x_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (en) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_val_q <= in_val;
    end
  end

  mvp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (s1_ctl_q),
    .a_i     (s1_val_q),
    .x_i     (x_rd),
    .res_o   (res),
    .res_d_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res_d.valid && res_d.lastcol;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res_d.valid && res_d.lastcol) begin
      out_row_q  <= res_d.row;
      out_val_q  <= res_d.acc;
      out_last_q <= res_d.lastrow;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-ACC_W-ROW_W){1'b0}}, out_val_q, out_row_q};

`ifndef ASSERT_OFF
  a_vec_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && (kind == KIND_VECTOR)) |=> !s1_ctl_q.valid)
    else $error("vector load entered the MAC pipeline");

  a_out_from_lastcol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(res.valid && res.lastcol && en))
    else $error("result without a last-column element");

  a_stall_holds_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(res.acc) && $stable(s1_ctl_q)))
    else $error("pipeline moved during an output stall");
`endif

endmodule
